// ----- hdl/cache_hit_tracker_dm_fa_fifo_unit_defines.svh -----
// Assertion macros shared by the cache hit tracker RTL.
// Depends on nothing; files that assert include it and provide clk and rst.
`ifndef CACHE_HIT_TRACKER_DM_FA_FIFO_UNIT_DEFINES_SVH
`define CACHE_HIT_TRACKER_DM_FA_FIFO_UNIT_DEFINES_SVH

// Condition and consequence in the same cycle.
`define CHDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence checked in the cycle after the condition.
`define CHDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/chdf_pkg.sv -----
// Shared constants, command and status types for the cache hit tracker.
// Depends on nothing; every RTL module refers to it by scoped names.
package chdf_pkg;

  localparam int ADDR_W      = 32;
  localparam int LINE_BYTES  = 64;
  localparam int OFFSET_W    = $clog2(LINE_BYTES);
  localparam int TAG_W       = ADDR_W - OFFSET_W;
  localparam int MAX_LINES   = 64;
  localparam int SLOT_W      = $clog2(MAX_LINES);
  localparam int LOG_W       = $clog2(SLOT_W + 1);
  localparam int SIZE_W      = 4;
  localparam int SIZE_MIN    = 7;
  localparam int SIZE_MAX    = 12;
  localparam int SIZE_RESET  = 10;
  localparam int CNT_W       = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_LOG2   = 2'd0,
    REG_FULLY_ASSOC = 2'd1,
    REG_SPLIT_MODE  = 2'd2
  } cfg_reg_t;

  // One classified access, passed from the front to the back.
  typedef struct packed {
    logic [TAG_W-1:0]  line_no;
    logic              fully_assoc;
    logic              side;
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] mask;
  } cmd_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Back-end lookup sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } back_state_t;

endpackage

// ----- hdl/chdf_front.sv -----
// Front end: configuration registers and classification of each access
// into line number, region base and region mask. Depends on chdf_pkg.
module chdf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [chdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [chdf_pkg::SIZE_W-1:0]         cfg_data,
  input  logic [chdf_pkg::ADDR_W-1:0]         address,
  input  logic                                is_data,
  output chdf_pkg::cmd_t                      cmd
);

  logic [chdf_pkg::SIZE_W-1:0] size_log2;
  logic                        fully_assoc;
  logic                        split_mode;

  logic [chdf_pkg::SIZE_W-1:0] size_clamped;
  logic [chdf_pkg::LOG_W-1:0]  lines_log2;
  logic [chdf_pkg::LOG_W-1:0]  region_log2;
  logic [chdf_pkg::SLOT_W:0]   region_size;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2   <= chdf_pkg::SIZE_W'(chdf_pkg::SIZE_RESET);
      fully_assoc <= 1'b0;
      split_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (chdf_pkg::cfg_reg_t'(cfg_index))
        chdf_pkg::REG_SIZE_LOG2:   size_log2   <= cfg_data;
        chdf_pkg::REG_FULLY_ASSOC: fully_assoc <= cfg_data[0];
        chdf_pkg::REG_SPLIT_MODE:  split_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the cache size and turn it into a line count exponent.
  always_comb begin
    if (size_log2 < chdf_pkg::SIZE_W'(chdf_pkg::SIZE_MIN)) begin
      size_clamped = chdf_pkg::SIZE_W'(chdf_pkg::SIZE_MIN);
    end else if (size_log2 > chdf_pkg::SIZE_W'(chdf_pkg::SIZE_MAX)) begin
      size_clamped = chdf_pkg::SIZE_W'(chdf_pkg::SIZE_MAX);
    end else begin
      size_clamped = size_log2;
    end

    if (size_clamped <= chdf_pkg::SIZE_W'(chdf_pkg::OFFSET_W)) begin
      lines_log2 = '0;
    end else if (size_clamped - chdf_pkg::SIZE_W'(chdf_pkg::OFFSET_W) >=
                 chdf_pkg::SIZE_W'(chdf_pkg::SLOT_W)) begin
      lines_log2 = chdf_pkg::LOG_W'(chdf_pkg::SLOT_W);
    end else begin
      lines_log2 = chdf_pkg::LOG_W'(size_clamped - chdf_pkg::SIZE_W'(chdf_pkg::OFFSET_W));
    end

    // A split half keeps at least one line.
    if (split_mode && lines_log2 != '0) begin
      region_log2 = lines_log2 - chdf_pkg::LOG_W'(1);
    end else begin
      region_log2 = lines_log2;
    end
    region_size = (chdf_pkg::SLOT_W + 1)'(1) << region_log2;
  end

  // Build the command for the back end.
  always_comb begin
    cmd.line_no     = address[chdf_pkg::ADDR_W-1:chdf_pkg::OFFSET_W];
    cmd.fully_assoc = fully_assoc;
    cmd.side        = split_mode & is_data;
    cmd.mask        = chdf_pkg::SLOT_W'(region_size - (chdf_pkg::SLOT_W + 1)'(1));
    cmd.base        = (split_mode && is_data) ? chdf_pkg::SLOT_W'(region_size) : '0;
  end

endmodule

// ----- hdl/chdf_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on chdf_pkg for the command and status types.
module chdf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chdf_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output chdf_pkg::cmd_t  head_cmd,
  output chdf_pkg::qstat_t qstat
);

  chdf_pkg::cmd_t                 entries [chdf_pkg::QUEUE_DEPTH];
  logic [chdf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [chdf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [chdf_pkg::QCNT_W-1:0]    count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + chdf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + chdf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + chdf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - chdf_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head_cmd    = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == chdf_pkg::QCNT_W'(chdf_pkg::QUEUE_DEPTH));

endmodule

// ----- hdl/chdf_back.sv -----
// Back end: tag memory, valid bits, FIFO pointers, lookup sequencer,
// hit and access counters and the result register. Depends on chdf_pkg.
module chdf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  chdf_pkg::cmd_t              head_cmd,
  input  chdf_pkg::qstat_t            qstat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [chdf_pkg::CNT_W-1:0]  hit_total,
  output logic [chdf_pkg::CNT_W-1:0]  access_total
);

  chdf_pkg::back_state_t          state;
  chdf_pkg::back_state_t          state_next;
  chdf_pkg::cmd_t                 cmd;
  logic [chdf_pkg::SLOT_W-1:0]    cur_slot;
  logic [chdf_pkg::SLOT_W-1:0]    idx;
  logic [chdf_pkg::MAX_LINES-1:0] valid;
  logic [chdf_pkg::SLOT_W-1:0]    fifo_ptr [2];
  logic [chdf_pkg::TAG_W-1:0]     tag_mem [chdf_pkg::MAX_LINES];
  logic [chdf_pkg::TAG_W-1:0]     rd_data;

  logic [chdf_pkg::SLOT_W-1:0]    first_slot;
  logic [chdf_pkg::SLOT_W-1:0]    rd_addr;
  logic [chdf_pkg::SLOT_W-1:0]    wr_addr;
  logic [chdf_pkg::SLOT_W-1:0]    evict_ptr;
  logic [chdf_pkg::SLOT_W-1:0]    evict_slot;
  logic                           wr_en;
  logic                           finish;
  logic                           hit_now;
  logic                           evict;
  logic                           step;
  logic                           slot_valid;
  logic                           tag_match;
  logic                           decided;
  logic                           out_free;

  // Lookup helpers.
  always_comb begin
    if (head_cmd.fully_assoc) begin
      first_slot = head_cmd.base;
    end else begin
      first_slot = head_cmd.base + (head_cmd.line_no[chdf_pkg::SLOT_W-1:0] & head_cmd.mask);
    end
    slot_valid = valid[cur_slot];
    tag_match  = slot_valid && (rd_data == cmd.line_no);
    evict_ptr  = fifo_ptr[cmd.side] & cmd.mask;
    evict_slot = cmd.base + evict_ptr;
    decided    = !cmd.fully_assoc || tag_match || !slot_valid || (idx == cmd.mask);
    out_free   = !out_valid || out_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      chdf_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          state_next = chdf_pkg::ST_LOOKUP;
        end
      end
      chdf_pkg::ST_LOOKUP: begin
        if (finish) begin
          state_next = chdf_pkg::ST_IDLE;
        end
      end
      default: state_next = chdf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: reads, writes, result and pointer updates.
  always_comb begin
    pop     = 1'b0;
    rd_addr = cur_slot;
    wr_en   = 1'b0;
    wr_addr = cur_slot;
    finish  = 1'b0;
    hit_now = 1'b0;
    evict   = 1'b0;
    step    = 1'b0;
    case (state)
      chdf_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          pop     = 1'b1;
          rd_addr = first_slot;
        end
      end
      chdf_pkg::ST_LOOKUP: begin
        if (decided) begin
          if (out_free) begin
            finish  = 1'b1;
            hit_now = tag_match;
            if (!tag_match) begin
              wr_en = 1'b1;
              // A full associative region replaces at its FIFO pointer.
              if (cmd.fully_assoc && slot_valid) begin
                evict   = 1'b1;
                wr_addr = evict_slot;
              end
            end
          end
        end else begin
          step    = 1'b1;
          rd_addr = cur_slot + chdf_pkg::SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers, valid bits, pointers, counters and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chdf_pkg::ST_IDLE;
      valid        <= '0;
      fifo_ptr[0]  <= '0;
      fifo_ptr[1]  <= '0;
      hit_total    <= '0;
      access_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (evict) begin
        fifo_ptr[cmd.side] <= (evict_ptr + chdf_pkg::SLOT_W'(1)) & cmd.mask;
      end
      if (finish) begin
        out_valid <= 1'b1;
        if (hit_now && hit_total != '1) begin
          hit_total <= hit_total + chdf_pkg::CNT_W'(1);
        end
        if (access_total != '1) begin
          access_total <= access_total + chdf_pkg::CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Current command, scan position and result flag.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd      <= head_cmd;
      cur_slot <= first_slot;
      idx      <= '0;
    end else if (step) begin
      cur_slot <= cur_slot + chdf_pkg::SLOT_W'(1);
      idx      <= idx + chdf_pkg::SLOT_W'(1);
    end
    if (finish) begin
      hit <= hit_now;
    end
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= cmd.line_no;
    end
    rd_data <= tag_mem[rd_addr];
  end

endmodule

// ----- hdl/cache_hit_tracker_dm_fa_fifo_unit.sv -----
// Top level of the tag-only cache hit tracker: front end, command queue,
// back end. Depends on chdf_pkg, chdf_front, chdf_queue, chdf_back.
//
//   Channel  Handshake            Word
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_ready    address, is_data
//   out      out_valid/out_ready  hit, hit_total, access_total
//
// In the back end a direct-mapped access is dequeued and read, then
// compared and updated. A fully associative access scans its region one
// tag memory read per cycle until it hits, finds an invalid slot or ends.
// The tag memory's single read port sets this scan rate.
// Reset clears the valid bits, FIFO pointers and counters at once.
// A result waiting in the output register stalls the back end only when it
// is ready to finish the next access; the queue accepts inputs while it has room.
`include "cache_hit_tracker_dm_fa_fifo_unit_defines.svh"

module cache_hit_tracker_dm_fa_fifo_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [chdf_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [chdf_pkg::ADDR_W-1:0]         address,
  input  logic                                is_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [chdf_pkg::CNT_W-1:0]          hit_total,
  output logic [chdf_pkg::CNT_W-1:0]          access_total
);

  chdf_pkg::cmd_t   front_cmd;
  chdf_pkg::cmd_t   head_cmd;
  chdf_pkg::qstat_t qstat;
  logic             push;
  logic             pop;

  // Configuration is always taken; input flows while the queue has room.
  assign cfg_ready = 1'b1;
  assign in_ready  = !qstat.full;
  assign push      = in_valid && in_ready;

  chdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .address   (address),
    .is_data   (is_data),
    .cmd       (front_cmd)
  );

  chdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  chdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_cmd     (head_cmd),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_total    (hit_total),
    .access_total (access_total)
  );

  // The back end only dequeues a command that is there.
  `CHDF_ASSERT_NOW(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")

  // Hits never outnumber accesses.
  `CHDF_ASSERT_NOW(a_hits_le_access, out_valid, hit_total <= access_total, "hit count too large")

  // A hit result always carries a nonzero hit count.
  `CHDF_ASSERT_NOW(a_hit_counted, out_valid && hit, hit_total != '0, "hit not counted")

  // A new result after a taken one has advanced the access count.
  `CHDF_ASSERT_NEXT(a_access_step, out_valid && out_ready && access_total != '1, !out_valid || access_total != $past(access_total), "access count did not advance")

endmodule
